/* hw/rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the balance pid controller
// Field widths, register indexes, reset values, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // fixed point format
  localparam int FRAC_BITS_DEF = 16;
  localparam int SPLIT_BITS    = 24;   // integral split into high and low part
  localparam int TERM_SAT_EXP  = 50;   // integral term limited to +/- 2^50

  // field widths
  localparam int ANG_W   = 19;
  localparam int RATE_W  = 23;
  localparam int GAIN_W  = 32;
  localparam int LIM_W   = 27;
  localparam int DB_W    = 17;
  localparam int DT_W    = 17;
  localparam int CMD_W   = 28;
  localparam int INT_W   = 40;
  localparam int E_W     = ANG_W + 1;
  localparam int R_W     = RATE_W + 1;

  // shared multiplier and wide accumulators
  localparam int MA_W    = GAIN_W;
  localparam int MB_W    = SPLIT_BITS + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 58;

  // ports
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_ANGLE_TARGET   = 3'd3,
    REG_RATE_TARGET    = 3'd4,
    REG_OUTPUT_LIMIT   = 3'd5,
    REG_ERROR_DEADBAND = 3'd6,
    REG_STEP_TIME      = 3'd7
  } reg_idx_t;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST       = 32'd65536;
  localparam logic [GAIN_W-1:0] GAIN_I_RST       = 32'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST       = 32'd0;
  localparam logic [ANG_W-1:0]  ANGLE_TARGET_RST = 19'd0;
  localparam logic [RATE_W-1:0] RATE_TARGET_RST  = 23'd0;
  localparam logic [LIM_W-1:0]  OUTPUT_LIMIT_RST = 27'd131072000;
  localparam logic [DB_W-1:0]   DEADBAND_RST     = 17'd197;
  localparam logic [DT_W-1:0]   STEP_TIME_RST    = 17'd655;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IH,
    ST_MUL_IL,
    ST_ISUM,
    ST_USUM,
    ST_CHECK,
    ST_INTEG,
    ST_OUT
  } state_t;

  // operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_KP_E,
    MUL_KD_R,
    MUL_KI_HI,
    MUL_KI_LO,
    MUL_E_DT
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;     // take input request, form errors
    mul_sel_t mul_sel;
    logic     pd_init;  // pd = p term
    logic     pd_add;   // pd += d term
    logic     ihi_ld;   // high part of integral term
    logic     isum_ld;  // full integral term
    logic     usum_ld;  // raw command
    logic     chk_ld;   // capture clamp flag
    logic     int_upd;  // integral += e*dt
    logic     out_ld;   // load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clamp;
  } dp_stat_t;

endpackage

/* hw/rtl/bpa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl: sequencer of the balance pid controller
// Steps the shared multiplier through the p, d and integral products, takes
// the anti-windup decision and hands results to the output register.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bpa_pkg::dp_cmd_t  cmd,
  input  bpa_pkg::dp_stat_t stat
);
  import bpa_pkg::*;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_MUL_P;
          second_nxt = 1'b0;
        end
      end
      ST_MUL_P:  state_nxt = ST_MUL_D;
      ST_MUL_D:  state_nxt = ST_MUL_IH;
      ST_MUL_IH: state_nxt = ST_MUL_IL;
      ST_MUL_IL: state_nxt = ST_ISUM;
      ST_ISUM:   state_nxt = ST_USUM;
      ST_USUM:   state_nxt = second_r ? ST_OUT : ST_CHECK;
      ST_CHECK: begin
        state_nxt = stat.clamp ? ST_OUT : ST_INTEG;
      end
      ST_INTEG: begin
        state_nxt  = ST_MUL_IH;
        second_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_KP_E;
    unique case (state_r)
      ST_IDLE:   cmd.load = accept;
      ST_MUL_P:  cmd.mul_sel = MUL_KP_E;
      ST_MUL_D: begin
        cmd.mul_sel = MUL_KD_R;
        cmd.pd_init = 1'b1;
      end
      ST_MUL_IH: begin
        cmd.mul_sel = MUL_KI_HI;
        cmd.pd_add  = !second_r;
      end
      ST_MUL_IL: begin
        cmd.mul_sel = MUL_KI_LO;
        cmd.ihi_ld  = 1'b1;
      end
      ST_ISUM:   cmd.isum_ld = 1'b1;
      ST_USUM:   cmd.usum_ld = 1'b1;
      ST_CHECK: begin
        cmd.mul_sel = MUL_E_DT;
        cmd.chk_ld  = 1'b1;
      end
      ST_INTEG:  cmd.int_upd = 1'b1;
      ST_OUT:    cmd.out_ld = out_free;
      default:   cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/bpa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dp: datapath of the balance pid controller
// Holds the setup registers, errors, integral and result register, and one
// shared 32x25 signed multiplier whose product is registered every cycle.
// ----------------------------------------------------------------------------
module bpa_dp #(
  parameter int FRAC_BITS = bpa_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bpa_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic [bpa_pkg::ANG_W-1:0]    pitch_angle,
  input  logic [bpa_pkg::RATE_W-1:0]   pitch_rate,
  input  logic                         clear_integral,
  input  bpa_pkg::dp_cmd_t             cmd,
  output bpa_pkg::dp_stat_t            stat,
  output logic [bpa_pkg::CMD_W-1:0]    drive_command,
  output logic                         windup_clamp
);
  import bpa_pkg::*;

  localparam int SHIFT_S = SPLIT_BITS - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] TERM_SAT = ACC_W'(64'sd1 <<< TERM_SAT_EXP);
  localparam logic signed [ACC_W-1:0] HI_BOUND = TERM_SAT >>> SHIFT_S;
  localparam logic signed [INT_W:0]   INT_MAX  = {2'b00, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W:0]   INT_MIN  = {2'b11, {(INT_W-1){1'b0}}};

  // setup registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [ANG_W-1:0]  angle_target_r;
  logic signed [RATE_W-1:0] rate_target_r;
  logic [LIM_W-1:0]         output_limit_r;
  logic [DB_W-1:0]          error_deadband_r;
  logic [DT_W-1:0]          step_time_r;

  // working registers
  logic signed [E_W-1:0]    e_r;
  logic signed [R_W-1:0]    rerr_r;
  logic signed [INT_W-1:0]  integral_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  pd_r, ihi_r, iterm_r, u_r;
  logic                     clamp_r;
  logic [CMD_W-1:0]         drive_r;

  logic signed [E_W-1:0]    e_raw;
  logic [E_W-1:0]           e_mag;
  logic signed [R_W-1:0]    rerr_nxt;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext, fshift, ihi_nxt, isum_raw, iterm_nxt;
  logic signed [ACC_W-1:0]  lim_pos, lim_neg, u_lim;
  logic signed [INT_W:0]    int_sum;
  logic signed [INT_W-1:0]  int_nxt;
  logic                     clamp_now;

  // setup register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r         <= GAIN_P_RST;
      gain_i_r         <= GAIN_I_RST;
      gain_d_r         <= GAIN_D_RST;
      angle_target_r   <= ANGLE_TARGET_RST;
      rate_target_r    <= RATE_TARGET_RST;
      output_limit_r   <= OUTPUT_LIMIT_RST;
      error_deadband_r <= DEADBAND_RST;
      step_time_r      <= STEP_TIME_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_GAIN_P:         gain_p_r         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         gain_i_r         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         gain_d_r         <= cfg_wdata[GAIN_W-1:0];
        REG_ANGLE_TARGET:   angle_target_r   <= cfg_wdata[ANG_W-1:0];
        REG_RATE_TARGET:    rate_target_r    <= cfg_wdata[RATE_W-1:0];
        REG_OUTPUT_LIMIT:   output_limit_r   <= cfg_wdata[LIM_W-1:0];
        REG_ERROR_DEADBAND: error_deadband_r <= cfg_wdata[DB_W-1:0];
        REG_STEP_TIME:      step_time_r      <= cfg_wdata[DT_W-1:0];
        default:            gain_p_r         <= gain_p_r;
      endcase
    end
  end

  // angle error with deadband, rate error
  always_comb begin
    e_raw    = E_W'(angle_target_r) - E_W'($signed(pitch_angle));
    e_mag    = e_raw[E_W-1] ? E_W'(-e_raw) : E_W'(e_raw);
    rerr_nxt = R_W'(rate_target_r) - R_W'($signed(pitch_rate));
  end

  // shared multiplier operands
  always_comb begin
    mul_a = gain_p_r;
    mul_b = MB_W'(e_r);
    case (cmd.mul_sel)
      MUL_KP_E: begin
        mul_a = gain_p_r;
        mul_b = MB_W'(e_r);
      end
      MUL_KD_R: begin
        mul_a = gain_d_r;
        mul_b = MB_W'(rerr_r);
      end
      MUL_KI_HI: begin
        mul_a = gain_i_r;
        mul_b = MB_W'($signed(integral_r[INT_W-1:SPLIT_BITS]));
      end
      MUL_KI_LO: begin
        mul_a = gain_i_r;
        mul_b = $signed({1'b0, integral_r[SPLIT_BITS-1:0]});
      end
      MUL_E_DT: begin
        mul_a = MA_W'(e_r);
        mul_b = $signed({{(MB_W-DT_W){1'b0}}, step_time_r});
      end
      default: begin
        mul_a = gain_p_r;
        mul_b = MB_W'(e_r);
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // product terms, saturation of the integral term
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    fshift   = ACC_W'(prod_r >>> FRAC_BITS);
    if (prod_ext > HI_BOUND) begin
      ihi_nxt = TERM_SAT;
    end else if (prod_ext < -HI_BOUND) begin
      ihi_nxt = -TERM_SAT;
    end else begin
      ihi_nxt = prod_ext <<< SHIFT_S;
    end
    isum_raw = ihi_r + fshift;
    if (isum_raw > TERM_SAT) begin
      iterm_nxt = TERM_SAT;
    end else if (isum_raw < -TERM_SAT) begin
      iterm_nxt = -TERM_SAT;
    end else begin
      iterm_nxt = isum_raw;
    end
  end

  // integral update with saturation at its width
  always_comb begin
    int_sum = (INT_W+1)'(integral_r) + (INT_W+1)'(fshift);
    if (int_sum > INT_MAX) begin
      int_nxt = INT_MAX[INT_W-1:0];
    end else if (int_sum < INT_MIN) begin
      int_nxt = INT_MIN[INT_W-1:0];
    end else begin
      int_nxt = int_sum[INT_W-1:0];
    end
  end

  // saturation test and output limiting
  always_comb begin
    lim_pos   = $signed({{(ACC_W-LIM_W){1'b0}}, output_limit_r});
    lim_neg   = -lim_pos;
    clamp_now = ((u_r > lim_pos) && (e_r > 0)) || ((u_r < lim_neg) && (e_r < 0));
    if (u_r > lim_pos) begin
      u_lim = lim_pos;
    end else if (u_r < lim_neg) begin
      u_lim = lim_neg;
    end else begin
      u_lim = u_r;
    end
  end

  assign stat.clamp = clamp_now;

  // integral state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
    end else if (cmd.load && clear_integral) begin
      integral_r <= '0;
    end else if (cmd.int_upd) begin
      integral_r <= int_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      e_r    <= (e_mag < E_W'(error_deadband_r)) ? '0 : e_raw;
      rerr_r <= rerr_nxt;
    end
    if (cmd.pd_init) begin
      pd_r <= fshift;
    end else if (cmd.pd_add) begin
      pd_r <= pd_r + fshift;
    end
    if (cmd.ihi_ld) begin
      ihi_r <= ihi_nxt;
    end
    if (cmd.isum_ld) begin
      iterm_r <= iterm_nxt;
    end
    if (cmd.usum_ld) begin
      u_r <= pd_r + iterm_r;
    end
    if (cmd.chk_ld) begin
      clamp_r <= clamp_now;
    end
    if (cmd.out_ld) begin
      drive_r      <= u_lim[CMD_W-1:0];
      windup_clamp <= clamp_r;
    end
  end

  assign drive_command = drive_r;

endmodule

/* hw/rtl/balance_pid_antiwindup.sv */
`timescale 1ns / 1ps
// sequence: p, d and integral products, the sums and the clamp check, then the
//   result register; an integral update reruns the integral products and sums
// flow: one request at a time, the next one taken once the result is
//   registered, set by the single shared multiplier
// reset: synchronous active-low rst_n restores register defaults, zeroes the
//   integral and empties the result register
// ----------------------------------------------------------------------------
// balance_pid_antiwindup: pitch balance pid with conditional integration
// Deadbanded angle error, pid command limited to +/- output_limit, integral
// held while the command saturates in the direction of the error.
// ----------------------------------------------------------------------------
module balance_pid_antiwindup #(
  parameter int FRAC_BITS = bpa_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bpa_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [bpa_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pitch_angle [18:0], pitch_rate [41:19], zero fill [47:42]
  input  logic [bpa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // clear_integral
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // drive_command [27:0], zero fill [31:28]
  output logic [bpa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // windup_clamp
  output logic                               out_tuser
);
  import bpa_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CMD_W-1:0] drive_command;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // arithmetic and state
  bpa_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .pitch_angle    (in_tdata[ANG_W-1:0]),
    .pitch_rate     (in_tdata[ANG_W+RATE_W-1:ANG_W]),
    .clear_integral (in_tuser),
    .cmd            (cmd),
    .stat           (stat),
    .drive_command  (drive_command),
    .windup_clamp   (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W-CMD_W){1'b0}}, drive_command};

endmodule

/* hw/rtl/bpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker: port-level checks of the balance pid controller
// Watches the stream ports for one-at-a-time operation, reset and stalls.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input ready drops once a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a request was taken");

  // a request cannot finish in the cycle after it was taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // stalled result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind balance_pid_antiwindup bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the balance pid with conditional integration
// Sends pitch requests on the input stream, predicts each drive command and
// clamp flag with a local fixed point model of the controller, and compares
// every result in order. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     STALL_LIMIT = 4000;
  localparam int     HOLD_CYCLES = 300;
  localparam longint TERM_SAT    = longint'(1) << TERM_SAT_EXP;
  localparam longint INTEG_MAX   = (longint'(1) << (INT_W - 1)) - 1;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;

  typedef struct packed {
    logic              clear;
    logic [RATE_W-1:0] rate;
    logic [ANG_W-1:0]  angle;
  } pitch_sample_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clamp;
  } drive_result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [ANG_W-1:0]  ang_tgt;
    logic [RATE_W-1:0] rate_tgt;
    logic [LIM_W-1:0]  lim;
    logic [DB_W-1:0]   db;
    logic [DT_W-1:0]   dt;
  } pid_settings_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_AW-1:0]       cfg_addr   = '0;
  logic [CFG_DW-1:0]       cfg_wdata  = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;

  // bench copy of the controller settings
  pid_settings_t model_cfg = '{kp: GAIN_P_RST, ki: GAIN_I_RST, kd: GAIN_D_RST,
                               ang_tgt: ANGLE_TARGET_RST, rate_tgt: RATE_TARGET_RST,
                               lim: OUTPUT_LIMIT_RST, db: DEADBAND_RST,
                               dt: STEP_TIME_RST};
  longint        integral_acc = 0;
  drive_result_t expected_drive[$];
  drive_result_t front_expect;

  int  mismatch_count  = 0;
  int  requests_sent   = 0;
  int  results_seen    = 0;
  int  held_count      = 0;
  int  cleared_count   = 0;
  int  settings_loaded = 1;
  int  idle_cycles     = 0;
  int  hold_requests   = 0;
  int  holds_granted   = 0;
  int  hold_left       = 0;
  bit  steady_flow     = 1'b0;

  balance_pid_antiwindup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // pitch_angle, pitch_rate, zero fill
    .in_tuser   (in_tuser),    // clear_integral
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // drive_command, zero fill
    .out_tuser  (out_tuser)    // windup_clamp
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed point controller model
  // ---------------------------------------------------------------------------

  // product scaling, rounds toward minus infinity
  function automatic longint scaled(longint x);
    return x >>> FRAC;
  endfunction

  // ki * integral in two parts, limited to the term range
  function automatic longint integral_term(longint gain, longint acc);
    longint lo, hi, a, t, bound;
    lo    = acc & ((longint'(1) << SPLIT_BITS) - 1);
    hi    = acc >>> SPLIT_BITS;
    a     = gain * hi;
    bound = TERM_SAT >>> (SPLIT_BITS - FRAC);
    if (a > bound) t = TERM_SAT;
    else if (a < -bound) t = -TERM_SAT;
    else t = a <<< (SPLIT_BITS - FRAC);
    t = t + scaled(gain * lo);
    if (t > TERM_SAT) t = TERM_SAT;
    if (t < -TERM_SAT) t = -TERM_SAT;
    return t;
  endfunction

  function automatic longint raw_drive(longint e, longint rate_err);
    longint kp, ki, kd;
    kp = longint'($signed(model_cfg.kp));
    ki = longint'($signed(model_cfg.ki));
    kd = longint'($signed(model_cfg.kd));
    return scaled(kp * e) + integral_term(ki, integral_acc) + scaled(kd * rate_err);
  endfunction

  // one control step: clamp decision, integral update, limited command
  function automatic drive_result_t predict_drive(pitch_sample_t s);
    longint e, mag, rate_err, u, lim, next_acc;
    drive_result_t r;
    lim = longint'(model_cfg.lim);
    if (s.clear) integral_acc = 0;
    e   = longint'($signed(model_cfg.ang_tgt)) - longint'($signed(s.angle));
    mag = (e < 0) ? -e : e;
    if (mag < longint'(model_cfg.db)) e = 0;
    rate_err = longint'($signed(model_cfg.rate_tgt)) - longint'($signed(s.rate));
    u = raw_drive(e, rate_err);
    r.clamp = (u > lim && e > 0) || (u < -lim && e < 0);
    if (!r.clamp) begin
      next_acc = integral_acc + scaled(e * longint'(model_cfg.dt));
      if (next_acc > INTEG_MAX) next_acc = INTEG_MAX;
      if (next_acc < INTEG_MIN) next_acc = INTEG_MIN;
      integral_acc = next_acc;
      u = raw_drive(e, rate_err);
    end
    if (u > lim) u = lim;
    if (u < -lim) u = -lim;
    r.cmd = u[CMD_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pitch_sample_t make_sample(longint ang, longint rate, bit clr);
    pitch_sample_t s;
    s.angle = ang[ANG_W-1:0];
    s.rate  = rate[RATE_W-1:0];
    s.clear = clr;
    return s;
  endfunction

  // uniform in [-hi, hi], often scaled down toward zero
  function automatic longint rand_signed(int unsigned hi);
    longint r;
    r = longint'($urandom_range(2 * hi)) - longint'(hi);
    if ($urandom_range(1)) r = r >>> $urandom_range(16);
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    logic [GAIN_W-1:0] mag;
    mag = $urandom >> $urandom_range(31);
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom_range(1) ? -mag : mag;
    endcase
  endfunction

  function automatic logic [31:0] rand_magnitude(int unsigned hi, logic [31:0] full);
    case ($urandom_range(7))
      0: return '0;
      1: return hi;
      2: return full;
      default: return $urandom_range(hi) >> $urandom_range(12);
    endcase
  endfunction

  function automatic pid_settings_t rand_settings();
    pid_settings_t s;
    s.kp       = rand_gain();
    s.ki       = rand_gain();
    s.kd       = rand_gain();
    s.ang_tgt  = ($urandom_range(7) == 0) ? ANG_W'($urandom) : ANG_W'(rand_signed(205887));
    s.rate_tgt = ($urandom_range(7) == 0) ? RATE_W'($urandom) : RATE_W'(rand_signed(2293760));
    s.lim      = LIM_W'(rand_magnitude(131072000, 32'h07FF_FFFF));
    s.db       = DB_W'(rand_magnitude(65536, 32'h0001_FFFF));
    s.dt       = DT_W'(rand_magnitude(65536, 32'h0001_FFFF));
    return s;
  endfunction

  // mostly in range, some near the target inside and around the deadband
  function automatic pitch_sample_t rand_sample();
    longint ang, rate, span;
    span = longint'(model_cfg.db) + 2;
    case ($urandom_range(9))
      0: ang = $urandom;
      1: ang = longint'($signed(model_cfg.ang_tgt))
               + longint'($urandom_range(32'(2 * span))) - span;
      default: ang = rand_signed(205887);
    endcase
    rate = ($urandom_range(9) == 0) ? longint'($urandom) : rand_signed(2293760);
    return make_sample(ang, rate, $urandom_range(9) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // register writes and requests
  // ---------------------------------------------------------------------------

  task automatic write_register(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:         model_cfg.kp       = value;
      REG_GAIN_I:         model_cfg.ki       = value;
      REG_GAIN_D:         model_cfg.kd       = value;
      REG_ANGLE_TARGET:   model_cfg.ang_tgt  = value[ANG_W-1:0];
      REG_RATE_TARGET:    model_cfg.rate_tgt = value[RATE_W-1:0];
      REG_OUTPUT_LIMIT:   model_cfg.lim      = value[LIM_W-1:0];
      REG_ERROR_DEADBAND: model_cfg.db       = value[DB_W-1:0];
      REG_STEP_TIME:      model_cfg.dt       = value[DT_W-1:0];
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic apply_settings(input pid_settings_t s);
    write_register(REG_GAIN_P, s.kp);
    write_register(REG_GAIN_I, s.ki);
    write_register(REG_GAIN_D, s.kd);
    write_register(REG_ANGLE_TARGET, CFG_DW'(s.ang_tgt));
    write_register(REG_RATE_TARGET, CFG_DW'(s.rate_tgt));
    write_register(REG_OUTPUT_LIMIT, CFG_DW'(s.lim));
    write_register(REG_ERROR_DEADBAND, CFG_DW'(s.db));
    write_register(REG_STEP_TIME, CFG_DW'(s.dt));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // offer one request with random idle gaps before it
  task automatic send_sample(input pitch_sample_t s);
    while (!steady_flow && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ANG_W - RATE_W){1'b0}}, s.rate, s.angle};
    in_tuser  <= s.clear;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_drive.push_back(predict_drive(s));
    if (expected_drive[$].clamp) held_count++;
    if (s.clear) cleared_count++;
    requests_sent++;
  endtask

  // block idle once every expected result is in
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s at result %0d: got %0d expected %0d",
             what, results_seen, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result checking and receiver flow control
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_drive.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_tdata), 0);
        end else begin
          front_expect = expected_drive.pop_front();
          if (out_tdata[CMD_W-1:0] !== front_expect.cmd)
            report_mismatch("drive_command", longint'($signed(out_tdata[CMD_W-1:0])),
                            longint'($signed(front_expect.cmd)));
          if (out_tuser !== front_expect.clamp)
            report_mismatch("windup_clamp", longint'(out_tuser),
                            longint'(front_expect.clamp));
        end
        results_seen++;
      end
      // long hold-off on request, otherwise random stalls outside steady flow
      if (holds_granted != hold_requests) begin
        holds_granted <= hold_requests;
        hold_left     <= HOLD_CYCLES;
        out_tready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady_flow || ($urandom_range(99) >= 13);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results pending",
               idle_cycles, expected_drive.size());
      $display("[balance_pid_antiwindup] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: unity p gain, deadband edges, ends of the sample range
  task automatic test_default_settings();
    send_sample(make_sample(0, 0, 1'b0));
    send_sample(make_sample(196, 0, 1'b0));
    send_sample(make_sample(-197, 0, 1'b0));
    send_sample(make_sample(197, 0, 1'b0));
    send_sample(make_sample(205887, 2293760, 1'b0));
    send_sample(make_sample(-205887, -2293760, 1'b0));
    send_sample(make_sample(1000, 0, 1'b1));
    send_sample(make_sample(-1000, 1, 1'b0));
    drain_results();
  endtask

  // saturation with and against the error, then a zero limit
  task automatic test_windup_clamp();
    pid_settings_t s;
    s.kp = 32'h0100_0000;  s.ki = 32'h0010_0000;  s.kd = 32'h0001_0000;
    s.ang_tgt = '0;        s.rate_tgt = '0;
    s.lim = 655360;        s.db = '0;             s.dt = 65536;
    apply_settings(s);
    send_sample(make_sample(-65536, 0, 1'b0));
    send_sample(make_sample(65536, 0, 1'b0));
    send_sample(make_sample(0, -2293760, 1'b0));
    send_sample(make_sample(-100, 2293760, 1'b0));
    send_sample(make_sample(50, 0, 1'b1));
    drain_results();
    s.lim = '0;
    apply_settings(s);
    send_sample(make_sample(-1000, 0, 1'b0));
    send_sample(make_sample(1000, 0, 1'b0));
    send_sample(make_sample(0, 0, 1'b1));
    drain_results();
  endtask

  // all registers at their top, then at their bottom or full bit width
  task automatic test_register_extremes();
    pid_settings_t s;
    s.kp = 32'h7FFF_FFFF;  s.ki = 32'h7FFF_FFFF;  s.kd = 32'h7FFF_FFFF;
    s.ang_tgt = 205887;    s.rate_tgt = 2293760;
    s.lim = 131072000;     s.db = 65536;          s.dt = 65536;
    apply_settings(s);
    send_sample(make_sample(-205887, 0, 1'b0));
    send_sample(make_sample(205787, 0, 1'b0));
    send_sample(make_sample(205887, -2293760, 1'b0));
    send_sample(make_sample(0, 0, 1'b1));
    drain_results();
    s.kp = 32'h8000_0000;  s.ki = 32'h8000_0000;  s.kd = 32'h8000_0000;
    s.ang_tgt = 19'h40000; s.rate_tgt = 23'h400000;
    s.lim = 27'h7FF_FFFF;  s.db = 17'h1FFFF;      s.dt = 17'h1FFFF;
    apply_settings(s);
    send_sample(make_sample(19'h3FFFF, 23'h3FFFFF, 1'b0));
    send_sample(make_sample(19'h40000, 23'h400000, 1'b0));
    send_sample(make_sample(205887, 0, 1'b0));
    send_sample(make_sample(-205887, 0, 1'b1));
    drain_results();
  endtask

  // random register settings, each followed by a run of random requests
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings(rand_settings());
      repeat (70) send_sample(rand_sample());
      drain_results();
    end
  endtask

  // back to back traffic, no idling on either side
  task automatic test_steady_stream();
    apply_settings(rand_settings());
    steady_flow <= 1'b1;
    repeat (40) send_sample(rand_sample());
    drain_results();
    steady_flow <= 1'b0;
  endtask

  // receiver holds off while requests keep coming, input must stall
  task automatic test_output_backpressure();
    apply_settings(rand_settings());
    hold_requests <= hold_requests + 1;
    repeat (20) send_sample(rand_sample());
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_settings();
    test_windup_clamp();
    test_register_extremes();
    test_random_settings();
    test_steady_stream();
    test_output_backpressure();
    repeat (20) @(posedge clk);
    $display("summary: %0d requests checked under %0d register settings",
             requests_sent, settings_loaded);
    $display("summary: integration held on %0d steps, integral cleared on %0d",
             held_count, cleared_count);
    if (mismatch_count == 0) begin
      $display("[balance_pid_antiwindup] OK");
    end else begin
      $display("[balance_pid_antiwindup] ERROR");
    end
    $finish;
  end

endmodule
